FILE: hdl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg: shared widths, types and helpers
// Widths follow the coordinate width, plus the cell state carried
// along the square root and divider chains.
// ----------------------------------------------------------------------------
package psd_pkg;

  // coordinate, difference, quotient, radicand, dividend and output widths
  localparam int CW  = 25;
  localparam int DW  = CW + 1;
  localparam int QW  = DW + 1;
  localparam int RW  = 2 * DW;
  localparam int DVW = DW + QW;
  localparam int PW  = QW + 1;
  localparam int OW  = CW + 2;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  // state of one square root cell: radicand bits left, partial remainder, root
  typedef struct packed {
    logic [RW-1:0]   rad;
    logic [DW+1:0]   rem;
    logic [DW-1:0]   root;
  } sqrt_st_t;

  // state of one divider cell: remainder, dividend bits left, quotient, divisor
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
    logic [DW-1:0] dvs;
  } div_st_t;

  // per-item side data that rides along the front part of the pipe
  typedef struct packed {
    coord_t [2:0]           p;
    coord_t [2:0]           s;
    coord_t [2:0]           e;
    logic   [2:0][DW-1:0]   dmag;
    logic   [2:0]           dneg;
    logic                   dtneg;
    logic signed [PW-1:0]   proj;
    logic   [DW-1:0]        len;
    logic                   pre_start;
    logic                   beyond;
  } side_t;

  // per-item data for the final distance part of the pipe
  typedef struct packed {
    coord_t [2:0]         p;
    coord_t [2:0]         sel;
    logic signed [PW-1:0] proj;
    logic                 outside;
  } tail_t;

  // clamp the projection to the output width
  function automatic logic signed [OW-1:0] sat_proj(input logic signed [PW-1:0] v);
    logic signed [OW-1:0] r;
    if (!v[PW-1] && (v[PW-2:OW-1] != '0)) begin
      r = {1'b0, {(OW-1){1'b1}}};
    end else if (v[PW-1] && (v[PW-2:OW-1] != '1)) begin
      r = {1'b1, {(OW-1){1'b0}}};
    end else begin
      r = v[OW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/psd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// psd_sqrt_cell: one digit of an integer square root
// Brings in two radicand bits, tries the next root bit and hands the
// updated remainder and root to the next cell.
// ----------------------------------------------------------------------------
module psd_sqrt_cell (
  input  logic               clk,
  input  logic               en,
  input  psd_pkg::sqrt_st_t  st_i,
  output psd_pkg::sqrt_st_t  st_r
);

  logic [psd_pkg::DW+3:0] cur;
  logic [psd_pkg::DW+3:0] trial;
  logic [psd_pkg::DW+3:0] diff;
  logic                   take;
  psd_pkg::sqrt_st_t      st_nxt;

  // try the next root bit
  always_comb begin
    cur    = {st_i.rem, st_i.rad[psd_pkg::RW-1:psd_pkg::RW-2]};
    trial  = {2'b00, st_i.root, 2'b01};
    diff   = cur - trial;
    take   = (cur >= trial);
    st_nxt.rad  = {st_i.rad[psd_pkg::RW-3:0], 2'b00};
    st_nxt.rem  = take ? diff[psd_pkg::DW+1:0] : cur[psd_pkg::DW+1:0];
    st_nxt.root = {st_i.root[psd_pkg::DW-2:0], take};
  end

  // advance when the pipe moves
  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: hdl/psd_div_cell.sv
// ----------------------------------------------------------------------------
// psd_div_cell: one step of restoring division
// Shifts one dividend bit into the remainder, subtracts the divisor when
// it fits and appends the quotient bit.
// ----------------------------------------------------------------------------
module psd_div_cell (
  input  logic              clk,
  input  logic              en,
  input  psd_pkg::div_st_t  st_i,
  output psd_pkg::div_st_t  st_r
);

  logic [psd_pkg::DW:0] cur;
  logic [psd_pkg::DW:0] diff;
  logic                 take;
  psd_pkg::div_st_t     st_nxt;

  // compare and subtract
  always_comb begin
    cur  = {st_i.rem, st_i.low[psd_pkg::QW-1]};
    diff = cur - {1'b0, st_i.dvs};
    take = (cur >= {1'b0, st_i.dvs});
    st_nxt.rem = take ? diff[psd_pkg::DW-1:0] : cur[psd_pkg::DW-1:0];
    st_nxt.low = {st_i.low[psd_pkg::QW-2:0], 1'b0};
    st_nxt.quo = {st_i.quo[psd_pkg::QW-2:0], take};
    st_nxt.dvs = st_i.dvs;
  end

  // advance when the pipe moves
  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: hdl/point_segment_distance_3d.sv
// ----------------------------------------------------------------------------
// point_segment_distance_3d: distance from a point to a 3D segment
// Fixed point in, projection length, closest point and signed distance out.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) takes one item per cycle while
// in_stall is low: the point and both segment ends. The result channel
// (out_valid, out_stall) gives one item per input item, in order. Throughput
// is one item per clock while out_stall holds no result. The pipe is a chain
// of DW square root cells for the segment length, QW divider cells for the
// projection, three parallel chains of QW divider cells for the closest
// point, and DW square root cells for the distance, plus 11 register stages.
// The whole pipe advances together; while a result waits in the output
// register under out_stall, in_stall is raised and every stage holds.
// A result still waiting does not block intake once it is taken.
// A synchronous reset (rst_n low) clears every valid bit; payload is
// not reset. No configuration and no state are kept between items.
// ----------------------------------------------------------------------------
module point_segment_distance_3d (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [psd_pkg::CW-1:0] in_pt_x,
  input  logic signed [psd_pkg::CW-1:0] in_pt_y,
  input  logic signed [psd_pkg::CW-1:0] in_pt_z,
  input  logic signed [psd_pkg::CW-1:0] in_seg_start_x,
  input  logic signed [psd_pkg::CW-1:0] in_seg_start_y,
  input  logic signed [psd_pkg::CW-1:0] in_seg_start_z,
  input  logic signed [psd_pkg::CW-1:0] in_seg_end_x,
  input  logic signed [psd_pkg::CW-1:0] in_seg_end_y,
  input  logic signed [psd_pkg::CW-1:0] in_seg_end_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [psd_pkg::OW-1:0] out_signed_dist,
  output logic signed [psd_pkg::OW-1:0] out_proj_len,
  output logic signed [psd_pkg::CW-1:0] out_near_x,
  output logic signed [psd_pkg::CW-1:0] out_near_y,
  output logic signed [psd_pkg::CW-1:0] out_near_z
);

  localparam int DW  = psd_pkg::DW;
  localparam int QW  = psd_pkg::QW;
  localparam int RW  = psd_pkg::RW;
  localparam int CW  = psd_pkg::CW;
  localparam int PW  = psd_pkg::PW;
  localparam int OW  = psd_pkg::OW;
  localparam int DVW = psd_pkg::DVW;

  logic en;

  logic                  out_valid_r;
  logic signed [OW-1:0]  dist_r;
  logic signed [OW-1:0]  proj_r;
  psd_pkg::coord_t       near_r [3];

  // the pipe moves unless a finished item is held at the output
  assign en       = ~(out_valid_r & out_stall);
  assign in_stall = ~en;

  // ---------------- stage 1: offsets ----------------
  logic               v1_r;
  psd_pkg::side_t     a1_r, a1_nxt;
  psd_pkg::diff_t     d1_r [3];
  psd_pkg::diff_t     t1_r [3];
  psd_pkg::diff_t     d1_nxt [3];
  psd_pkg::diff_t     t1_nxt [3];

  // form direction and offset from the start
  always_comb begin
    a1_nxt   = '0;
    a1_nxt.p = {in_pt_z, in_pt_y, in_pt_x};
    a1_nxt.s = {in_seg_start_z, in_seg_start_y, in_seg_start_x};
    a1_nxt.e = {in_seg_end_z, in_seg_end_y, in_seg_end_x};
    for (int i = 0; i < 3; i++) begin
      d1_nxt[i] = $signed({a1_nxt.e[i][CW-1], a1_nxt.e[i]})
                - $signed({a1_nxt.s[i][CW-1], a1_nxt.s[i]});
      t1_nxt[i] = $signed({a1_nxt.p[i][CW-1], a1_nxt.p[i]})
                - $signed({a1_nxt.s[i][CW-1], a1_nxt.s[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= a1_nxt;
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= d1_nxt[i];
        t1_r[i] <= t1_nxt[i];
      end
    end
  end

  // ---------------- stage 2: products ----------------
  logic                  v2_r;
  psd_pkg::side_t        a2_r, a2_nxt;
  logic [RW-1:0]         dsq2_r [3];
  logic signed [RW-1:0]  dtp2_r [3];
  logic signed [RW-1:0]  dsq2_nxt [3];
  logic signed [RW-1:0]  dtp2_nxt [3];

  // square the direction, dot it with the offset, keep magnitudes
  always_comb begin
    a2_nxt = a1_r;
    for (int i = 0; i < 3; i++) begin
      dsq2_nxt[i]       = d1_r[i] * d1_r[i];
      dtp2_nxt[i]       = d1_r[i] * t1_r[i];
      a2_nxt.dneg[i]    = d1_r[i][DW-1];
      a2_nxt.dmag[i]    = d1_r[i][DW-1] ? (-d1_r[i]) : d1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r <= a2_nxt;
      for (int i = 0; i < 3; i++) begin
        dsq2_r[i] <= dsq2_nxt[i];
        dtp2_r[i] <= dtp2_nxt[i];
      end
    end
  end

  // ---------------- stage 3: sums ----------------
  logic                v3_r;
  psd_pkg::side_t      a3_r;
  logic [RW-1:0]       dd3_r;
  logic signed [RW:0]  dt3_r;

  // add the three terms of each dot product
  always_ff @(posedge clk) begin
    if (en) begin
      a3_r  <= a2_r;
      dd3_r <= dsq2_r[0] + dsq2_r[1] + dsq2_r[2];
      dt3_r <= $signed({dtp2_r[0][RW-1], dtp2_r[0]})
             + $signed({dtp2_r[1][RW-1], dtp2_r[1]})
             + $signed({dtp2_r[2][RW-1], dtp2_r[2]});
    end
  end

  // ---------------- stage 4: dot product magnitude ----------------
  logic            v4_r;
  psd_pkg::side_t  a4_r, a4_nxt;
  logic [RW-1:0]   dd4_r;
  logic [RW-1:0]   dtm4_r;
  logic signed [RW:0] dt3_abs;

  assign dt3_abs = dt3_r[RW] ? (-dt3_r) : dt3_r;

  // record the sign of the dot product with the side data
  always_comb begin
    a4_nxt       = a3_r;
    a4_nxt.dtneg = dt3_r[RW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a4_r       <= a4_nxt;
      dd4_r      <= dd3_r;
      dtm4_r     <= dt3_abs[RW-1:0];
    end
  end

  // ---------------- segment length: square root chain ----------------
  psd_pkg::sqrt_st_t  sq_in;
  psd_pkg::sqrt_st_t  sq_st [DW];
  psd_pkg::side_t     sqa_r [DW];
  logic [RW-1:0]      sqdt_r [DW];
  logic               sqv_r [DW];

  always_comb begin
    sq_in.rad  = dd4_r;
    sq_in.rem  = '0;
    sq_in.root = '0;
  end

  for (genvar k = 0; k < DW; k++) begin : g_len
    psd_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .st_i ((k == 0) ? sq_in : sq_st[(k == 0) ? 0 : k-1]),
      .st_r (sq_st[k])
    );
  end

  // carry side data beside the cells
  always_ff @(posedge clk) begin
    if (en) begin
      sqa_r[0]  <= a4_r;
      sqdt_r[0] <= dtm4_r;
      for (int k = 1; k < DW; k++) begin
        sqa_r[k]  <= sqa_r[k-1];
        sqdt_r[k] <= sqdt_r[k-1];
      end
    end
  end

  // ---------------- projection: divider chain ----------------
  psd_pkg::div_st_t  dv_in;
  psd_pkg::div_st_t  dv_st [QW];
  psd_pkg::side_t    dva_r [QW];
  logic              dvv_r [QW];
  logic [DVW-1:0]    dv_dvd;

  always_comb begin
    dv_dvd    = {1'b0, sqdt_r[DW-1]};
    dv_in.rem = dv_dvd[DVW-1:QW];
    dv_in.low = dv_dvd[QW-1:0];
    dv_in.quo = '0;
    dv_in.dvs = sq_st[DW-1].root;
  end

  for (genvar k = 0; k < QW; k++) begin : g_proj
    psd_div_cell u_cell (
      .clk  (clk),
      .en   (en),
      .st_i ((k == 0) ? dv_in : dv_st[(k == 0) ? 0 : k-1]),
      .st_r (dv_st[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dva_r[0] <= sqa_r[DW-1];
      for (int k = 1; k < QW; k++) begin
        dva_r[k] <= dva_r[k-1];
      end
    end
  end

  // ---------------- stage P: signed projection and region ----------------
  logic                  vp_r;
  psd_pkg::side_t        ap_r, ap_nxt;
  logic signed [PW-1:0]  pq;

  // apply the sign, force zero for a zero-length segment, classify
  always_comb begin
    ap_nxt     = dva_r[QW-1];
    pq         = $signed({1'b0, dv_st[QW-1].quo});
    ap_nxt.len = dv_st[QW-1].dvs;
    if (dv_st[QW-1].dvs == '0) begin
      ap_nxt.proj = '0;
    end else if (dva_r[QW-1].dtneg) begin
      ap_nxt.proj = -pq;
    end else begin
      ap_nxt.proj = pq;
    end
    ap_nxt.pre_start = ap_nxt.proj[PW-1];
    ap_nxt.beyond = (ap_nxt.proj > $signed({{(PW-DW){1'b0}}, ap_nxt.len}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ap_r <= ap_nxt;
    end
  end

  // ---------------- stage M: direction times projection ----------------
  logic            vm_r;
  psd_pkg::side_t  am_r;
  logic [DVW-1:0]  prod_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      am_r <= ap_r;
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= ap_r.dmag[i] * ap_r.proj[QW-1:0];
      end
    end
  end

  // ---------------- closest point: three divider chains ----------------
  psd_pkg::div_st_t  nd_in [3];
  psd_pkg::div_st_t  nd_st [3][QW];
  psd_pkg::side_t    nda_r [QW];
  logic              ndv_r [QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nd_in[i].rem = prod_r[i][DVW-1:QW];
      nd_in[i].low = prod_r[i][QW-1:0];
      nd_in[i].quo = '0;
      nd_in[i].dvs = am_r.len;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    for (genvar k = 0; k < QW; k++) begin : g_near
      psd_div_cell u_cell (
        .clk  (clk),
        .en   (en),
        .st_i ((k == 0) ? nd_in[i] : nd_st[i][(k == 0) ? 0 : k-1]),
        .st_r (nd_st[i][k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nda_r[0] <= am_r;
      for (int k = 1; k < QW; k++) begin
        nda_r[k] <= nda_r[k-1];
      end
    end
  end

  // ---------------- stage N: pick the closest point ----------------
  logic                  vn_r;
  psd_pkg::tail_t        tn_r, tn_nxt;
  psd_pkg::side_t        an;
  logic signed [PW-1:0]  off;
  logic signed [PW-1:0]  nsum;

  // start, end, or foot of the perpendicular
  always_comb begin
    an             = nda_r[QW-1];
    tn_nxt.p       = an.p;
    tn_nxt.proj    = an.proj;
    tn_nxt.outside = an.pre_start | an.beyond;
    off            = '0;
    nsum           = '0;
    for (int i = 0; i < 3; i++) begin
      off  = $signed({1'b0, nd_st[i][QW-1].quo});
      if (an.dneg[i]) begin
        off = -off;
      end
      if (an.len == '0) begin
        off = '0;
      end
      nsum = $signed({{(PW-CW){an.s[i][CW-1]}}, an.s[i]}) + off;
      if (an.pre_start) begin
        tn_nxt.sel[i] = an.s[i];
      end else if (an.beyond) begin
        tn_nxt.sel[i] = an.e[i];
      end else begin
        tn_nxt.sel[i] = nsum[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tn_r <= tn_nxt;
    end
  end

  // ---------------- stages V, Q, R: squared distance ----------------
  logic            vv_r, vq_r, vr_r;
  psd_pkg::tail_t  tv_r, tq_r, tr_r;
  psd_pkg::diff_t  df_r [3];
  logic [RW-1:0]   fsq_r [3];
  logic [RW-1:0]   rad_r;
  logic signed [RW-1:0] fsq_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fsq_nxt[i] = df_r[i] * df_r[i];
    end
  end

  // difference, square, sum
  always_ff @(posedge clk) begin
    if (en) begin
      tv_r <= tn_r;
      tq_r <= tv_r;
      tr_r <= tq_r;
      for (int i = 0; i < 3; i++) begin
        df_r[i]  <= $signed({tn_r.p[i][CW-1], tn_r.p[i]})
                  - $signed({tn_r.sel[i][CW-1], tn_r.sel[i]});
        fsq_r[i] <= fsq_nxt[i];
      end
      rad_r <= fsq_r[0] + fsq_r[1] + fsq_r[2];
    end
  end

  // ---------------- distance: square root chain ----------------
  psd_pkg::sqrt_st_t  fs_in;
  psd_pkg::sqrt_st_t  fs_st [DW];
  psd_pkg::tail_t     ft_r [DW];
  logic               fv_r [DW];

  always_comb begin
    fs_in.rad  = rad_r;
    fs_in.rem  = '0;
    fs_in.root = '0;
  end

  for (genvar k = 0; k < DW; k++) begin : g_dist
    psd_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .st_i ((k == 0) ? fs_in : fs_st[(k == 0) ? 0 : k-1]),
      .st_r (fs_st[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ft_r[0] <= tr_r;
      for (int k = 1; k < DW; k++) begin
        ft_r[k] <= ft_r[k-1];
      end
    end
  end

  // ---------------- output register ----------------
  logic signed [OW-1:0] rmag;

  assign rmag = $signed({1'b0, fs_st[DW-1].root});

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= ft_r[DW-1].outside ? (-rmag) : rmag;
      proj_r <= psd_pkg::sat_proj(ft_r[DW-1].proj);
      for (int i = 0; i < 3; i++) begin
        near_r[i] <= ft_r[DW-1].sel[i];
      end
    end
  end

  // ---------------- valid bits ----------------
  // advance every valid bit with the pipe, clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vp_r <= 1'b0;
      vm_r <= 1'b0;
      vn_r <= 1'b0;
      vv_r <= 1'b0;
      vq_r <= 1'b0;
      vr_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < DW; k++) begin
        sqv_r[k] <= 1'b0;
        fv_r[k]  <= 1'b0;
      end
      for (int k = 0; k < QW; k++) begin
        dvv_r[k] <= 1'b0;
        ndv_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      sqv_r[0] <= v4_r;
      for (int k = 1; k < DW; k++) begin
        sqv_r[k] <= sqv_r[k-1];
        fv_r[k]  <= fv_r[k-1];
      end
      dvv_r[0] <= sqv_r[DW-1];
      ndv_r[0] <= vm_r;
      for (int k = 1; k < QW; k++) begin
        dvv_r[k] <= dvv_r[k-1];
        ndv_r[k] <= ndv_r[k-1];
      end
      vp_r <= dvv_r[QW-1];
      vm_r <= vp_r;
      vn_r <= ndv_r[QW-1];
      vv_r <= vn_r;
      vq_r <= vv_r;
      vr_r <= vq_r;
      fv_r[0] <= vr_r;
      out_valid_r <= fv_r[DW-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_signed_dist = dist_r;
  assign out_proj_len    = proj_r;
  assign out_near_x      = near_r[0];
  assign out_near_y      = near_r[1];
  assign out_near_z      = near_r[2];

  // ---------------- assertions ----------------
  // a held output freezes the last distance stage
  a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_stall) |-> $stable(fv_r[DW-1]))
    else $error("distance chain moved while the output was held");

  // a projection before the start never reports a positive distance
  a_before_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_proj_len[OW-1]) |-> (out_signed_dist <= 0))
    else $error("positive distance for a point before the start");

  // closest point chain divides by the segment length of its own item
  a_near_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    ndv_r[QW-1] |-> (nd_st[0][QW-1].dvs == nda_r[QW-1].len))
    else $error("closest point divisor out of step with its item");

endmodule
